// ===== rtl/core/ldc_pkg.sv =====
// shared types and constants of the length-prefixed datagram checker
package ldc_pkg;

  // stream markers and length bound
  localparam logic [7:0]  START_MARK = 8'd2;
  localparam logic [7:0]  END_MARK   = 8'd3;
  localparam logic [31:0] MIN_LENGTH = 32'd5;

  // register reset values
  localparam logic [23:0] MAX_LENGTH_RESET = 24'd131072;
  localparam logic [7:0]  MARKED_ID_RESET  = 8'd67;

  // configuration register indexes
  localparam logic [0:0] CFG_MAX_LENGTH = 1'b0;
  localparam logic [0:0] CFG_MARKED_ID  = 1'b1;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_SUM   = 3'd1;
  localparam logic [2:0] ST_BAD_START = 3'd2;
  localparam logic [2:0] ST_BAD_END   = 3'd3;
  localparam logic [2:0] ST_BAD_LEN   = 3'd4;

  // parser phase, one-hot
  typedef enum logic [6:0] {
    PH_LEN     = 7'b0000001,
    PH_START   = 7'b0000010,
    PH_ID      = 7'b0000100,
    PH_PAYLOAD = 7'b0001000,
    PH_END     = 7'b0010000,
    PH_CKLO    = 7'b0100000,
    PH_CKHI    = 7'b1000000
  } phase_t;

  // one result, dg_id in the lowest bits
  typedef struct packed {
    logic [2:0]  status;
    logic        is_marked;
    logic [15:0] sum_received;
    logic [15:0] sum_computed;
    logic [31:0] dg_length;
    logic [7:0]  dg_id;
  } result_t;

endpackage

// ===== rtl/core/ldc_parser.sv =====
// byte-wise datagram parser: phase tracking, running sum and result build
module ldc_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic [7:0]       data_byte,
  input  logic [23:0]      max_length,
  input  logic [7:0]       marked_id,
  output logic             res_valid,
  output ldc_pkg::result_t res
);
  import ldc_pkg::*;

  phase_t      phase, phase_next;
  logic [1:0]  len_idx, len_idx_next;
  logic [31:0] frame_length, frame_length_next;
  logic [23:0] remaining, remaining_next;
  logic [15:0] running_sum, running_sum_next;
  logic [7:0]  held_id, held_id_next;
  logic        start_ok, start_ok_next;
  logic        end_ok, end_ok_next;
  logic [7:0]  checksum_low, checksum_low_next;

  logic [31:0] len_word;
  logic        len_bad;
  logic [15:0] recv_sum;

  // length word as it stands after this byte
  always_comb begin
    if (len_idx == 2'd0) begin
      len_word = {24'd0, data_byte};
    end else begin
      len_word = frame_length | ({24'd0, data_byte} << {len_idx, 3'b000});
    end
  end

  assign len_bad = (len_word < MIN_LENGTH) || (len_word[31:24] != 8'd0) ||
                   (len_word[23:0] > max_length);
  assign recv_sum = {data_byte, checksum_low};

  always_comb begin
    phase_next        = phase;
    len_idx_next      = len_idx;
    frame_length_next = frame_length;
    remaining_next    = remaining;
    running_sum_next  = running_sum;
    held_id_next      = held_id;
    start_ok_next     = start_ok;
    end_ok_next       = end_ok;
    checksum_low_next = checksum_low;
    res_valid         = 1'b0;
    res               = '0;

    unique case (phase)
      PH_START: begin
        start_ok_next = (data_byte == START_MARK);
        phase_next    = PH_ID;
      end
      PH_ID: begin
        held_id_next     = data_byte;
        running_sum_next = {8'd0, data_byte};
        phase_next       = (remaining == 24'd0) ? PH_END : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        running_sum_next = running_sum + {8'd0, data_byte};
        remaining_next   = remaining - 24'd1;
        if (remaining == 24'd1) begin
          phase_next = PH_END;
        end
      end
      PH_END: begin
        end_ok_next = (data_byte == END_MARK);
        phase_next  = PH_CKLO;
      end
      PH_CKLO: begin
        checksum_low_next = data_byte;
        phase_next        = PH_CKHI;
      end
      PH_CKHI: begin
        res_valid        = 1'b1;
        res.dg_id        = held_id;
        res.dg_length    = frame_length;
        res.sum_computed = running_sum;
        res.sum_received = recv_sum;
        res.is_marked    = (held_id == marked_id);
        if (recv_sum != running_sum) begin
          res.status = ST_BAD_SUM;
        end else if (!start_ok) begin
          res.status = ST_BAD_START;
        end else if (!end_ok) begin
          res.status = ST_BAD_END;
        end else begin
          res.status = ST_OK;
        end
        phase_next   = PH_LEN;
        len_idx_next = 2'd0;
      end
      default: begin
        // length bytes; an illegal code also lands here
        frame_length_next = len_word;
        len_idx_next      = len_idx + 2'd1;
        phase_next        = PH_LEN;
        if (len_idx == 2'd3) begin
          remaining_next = len_word[23:0] - MIN_LENGTH[23:0];
          if (len_bad) begin
            res_valid     = 1'b1;
            res.dg_length = len_word;
            res.status    = ST_BAD_LEN;
          end else begin
            phase_next = PH_START;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_LEN;
      len_idx <= 2'd0;
    end else if (fire) begin
      phase   <= phase_next;
      len_idx <= len_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      frame_length <= frame_length_next;
      remaining    <= remaining_next;
      running_sum  <= running_sum_next;
      held_id      <= held_id_next;
      start_ok     <= start_ok_next;
      end_ok       <= end_ok_next;
      checksum_low <= checksum_low_next;
    end
  end

endmodule

// ===== rtl/core/length_prefixed_datagram_checker_top.sv =====
// top level of the length-prefixed datagram checker
// Takes a byte stream of back-to-back datagrams (4-byte little-endian length,
// start marker, id, payload, end marker, 16-bit little-endian additive
// checksum) and delivers one result per datagram on the master side: id,
// length, computed and received sums, the marked flag and a status (ok, bad
// checksum, bad start marker, bad end marker, bad length). A length under 5
// or above max_length gives a bad-length result as soon as its fourth byte
// arrives, after which the next length word is expected. One byte is taken
// per clock while the input side is not stalled: a request lands in an input
// register, the parser handles it combinationally against its phase register
// and writes any result to the output register. The input
// side stalls only when a byte that yields a result (last checksum byte or
// rejected length) meets a full output register that is not being drained.
// Configuration writes are taken in any cycle and are meant for idle periods.
module length_prefixed_datagram_checker_top (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // dg_id, dg_length, sum_computed,
                                      // sum_received, is_marked, status, zero pad
  // configuration writes
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,      // 0 max_length, 1 marked_id
  input  logic [23:0] cfg_wdata
);
  import ldc_pkg::*;

  // configuration registers
  logic [23:0] max_length;
  logic [7:0]  marked_id;

  // input register
  logic        in_valid;
  logic [7:0]  in_byte;

  // output register
  logic        out_valid;
  result_t     out_res;

  // parser hookup
  logic        proc_fire;
  logic        res_valid;
  result_t     res;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RESET;
      marked_id  <= MARKED_ID_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_LENGTH: max_length <= cfg_wdata;
        CFG_MARKED_ID:  marked_id  <= cfg_wdata[7:0];
        default:        ;
      endcase
    end
  end

  // a byte with no result never waits; one with a result needs a free slot
  assign proc_fire     = in_valid && (!res_valid || !out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || proc_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  ldc_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .fire       (proc_fire),
    .data_byte  (in_byte),
    .max_length (max_length),
    .marked_id  (marked_id),
    .res_valid  (res_valid),
    .res        (res)
  );

  // result register, refilled in the cycle it drains
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_fire && res_valid) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && res_valid) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'd0, out_res};

`ifndef NO_ASSERTIONS
  // bad-length results carry only the length
  a_bad_len_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.status == ST_BAD_LEN) |->
      (out_res.dg_id == 8'd0 && out_res.sum_computed == 16'd0 &&
       out_res.sum_received == 16'd0 && !out_res.is_marked))
    else $error("bad-length result with nonzero fields");

  // any other result came from an accepted length
  a_len_in_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.status != ST_BAD_LEN) |->
      (out_res.dg_length >= MIN_LENGTH && out_res.dg_length[31:24] == 8'd0))
    else $error("result from a length that should have been rejected");

  // never overwrite a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (proc_fire && res_valid && out_valid) |-> m_axis_tready)
    else $error("result register overwritten");

  // stall only with a byte held
  a_stall_holds_byte: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> in_valid)
    else $error("input stalled with empty input register");
`endif

endmodule
